>>> src/swpt_pkg.sv
`timescale 1ns / 1ps
package swpt_pkg;

	localparam int NUM_METRICS = 8;
	localparam int MAX_WINDOW  = 1024;
	localparam int IDX_W       = $clog2(MAX_WINDOW);
	localparam int CNT_W       = IDX_W + 1;
	localparam int MET_W       = 3;
	localparam int VAL_W       = 31;
	localparam int ADDR_W      = $clog2(NUM_METRICS * MAX_WINDOW);

	localparam logic [9:0] WIN_MIN   = 10'd10;
	localparam logic [9:0] WIN_MAX   = 10'd1000;
	localparam logic [9:0] WIN_RESET = 10'd100;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [MET_W-1:0] metric;
		logic [VAL_W-1:0] value;
	} cmd_t;

	// Window size after saturation into the legal range.
	function automatic logic [CNT_W-1:0] eff_window(input logic [9:0] w);
		logic [9:0] s;
		logic [CNT_W-1:0] r;
		s = w;
		if (s < WIN_MIN) s = WIN_MIN;
		if (s > WIN_MAX) s = WIN_MAX;
		r = CNT_W'(s);
		if (int'(s) > MAX_WINDOW) r = CNT_W'(MAX_WINDOW);
		return r;
	endfunction

endpackage

>>> src/swpt_front.sv
`timescale 1ns / 1ps
module swpt_front (
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             op,
	input  logic [2:0]             metric_index,
	input  logic signed [31:0]     sample_value,
	input  logic                   q_full,
	output logic                   q_push,
	output swpt_pkg::cmd_t         q_cmd
);
	import swpt_pkg::*;

	logic metric_ok;

	// A metric beyond the table turns an add into nothing and a query into an empty answer.
	assign metric_ok = int'(metric_index) < NUM_METRICS;
	assign in_stall  = q_full;

	always_comb begin
		q_cmd.metric = metric_index;
		q_cmd.value  = sample_value[31] ? '0 : sample_value[VAL_W-1:0];
		q_cmd.op     = OP_NONE;
		case (op)
			OP_ADD:   q_cmd.op = metric_ok ? OP_ADD : OP_NONE;
			OP_QUERY: q_cmd.op = OP_QUERY;
			OP_CLEAR: q_cmd.op = OP_CLEAR;
			default:  q_cmd.op = OP_NONE;
		endcase
		if (!metric_ok) q_cmd.metric = '0;
		if (q_cmd.op == OP_QUERY) q_cmd.value = metric_ok ? '0 : {VAL_W{1'b1}};
	end

	// Queries on a bad metric are flagged by an all-ones value the back end checks.
	assign q_push = in_valid && !q_full && (q_cmd.op != OP_NONE);
endmodule

>>> src/swpt_fifo.sv
`timescale 1ns / 1ps
module swpt_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swpt_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output swpt_pkg::cmd_t head
);
	import swpt_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> src/swpt_back.sv
`timescale 1ns / 1ps
module swpt_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [9:0]                    win_raw,
	input  logic                          cmd_valid,
	input  swpt_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [10:0]                   sample_count,
	output logic [30:0]                   last_value,
	output logic [30:0]                   median_value,
	output logic [30:0]                   p90_value
);
	import swpt_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SETUP = 9'b000000010,
		S_RDI   = 9'b000000100,
		S_LDI   = 9'b000001000,
		S_INNER = 9'b000010000,
		S_CHECK = 9'b000100000,
		S_MUL   = 9'b001000000,
		S_DIV   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [VAL_W-1:0] mem [NUM_METRICS * MAX_WINDOW];
	logic [VAL_W-1:0] rdata_q;
	logic [ADDR_W-1:0] raddr;
	logic              mem_we;
	logic [ADDR_W-1:0] waddr;

	logic [CNT_W-1:0] count_q [NUM_METRICS];
	logic [IDX_W-1:0] wp_q    [NUM_METRICS];

	logic [MET_W-1:0] qm_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] rank_q [4];
	logic [VAL_W-1:0] val_q  [4];
	logic             frac_q;
	logic [3:0]       k_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] cmp_q;
	logic             vld_s1;
	logic [CNT_W-1:0] lt_q;
	logic [CNT_W-1:0] eq_q;
	logic [VAL_W-1:0] vi_q;
	logic [VAL_W-1:0] last_q;
	logic [VAL_W-1:0] med_q;
	logic [VAL_W-1:0] p90_q;
	logic             found_q;
	logic [VAL_W-1:0] diff_q;
	logic [27:0]      quo_q;
	logic [VAL_W-1:0] qk_q;
	logic [3:0]       rem_q;
	logic [1:0]       dcnt_q;

	logic [CNT_W-1:0] n_new;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] win_eff;
	logic [13:0]      x9;
	logic [26:0]      xprod;
	logic [13:0]      q10;
	logic [13:0]      r10;
	logic [13:0]      q10c;
	logic [13:0]      r10c;
	logic [63:0]      recip;
	logic [6:0]       rk;
	logic [14:0]      tail;

	assign win_eff = eff_window(win_raw);
	assign cnt_inc = count_q[cmd.metric] + CNT_W'(1);
	assign n_new   = (int'(count_q[cmd.metric]) > MAX_WINDOW) ? CNT_W'(MAX_WINDOW)
	               : count_q[cmd.metric];

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign mem_we  = cmd_pop && cmd.op == OP_ADD;
	assign waddr   = {cmd.metric, wp_q[cmd.metric]};

	always_comb begin
		case (state_q)
			S_RDI:   raddr = {qm_q, oldest_q + i_q[IDX_W-1:0]};
			S_INNER: raddr = {qm_q, oldest_q + iss_q[IDX_W-1:0]};
			default: raddr = {qm_q, oldest_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= cmd.value;
		rdata_q <= mem[raddr];
	end

	// Divide by ten through a reciprocal, then one correcting step.
	always_comb begin
		x9    = 14'(pos_q) * 14'd9;
		xprod = 27'(x9) * 27'd6554;
		q10   = 14'(xprod >> 16);
		r10   = x9 - 14'(q10 * 14'd10);
		q10c  = q10;
		r10c  = r10;
		if (r10 >= 14'd10) begin
			q10c = q10 + 14'd1;
			r10c = r10 - 14'd10;
		end
	end

	// The p90 step splits the difference as 10*q + r, so floor(diff*k/10) is
	// q*k + floor(r*k/10). The quotient comes from an exact 32-bit reciprocal, and the
	// small remainder product is divided by a short reciprocal that is exact below 90.
	always_comb begin
		recip = 64'(diff_q) * 64'(32'hCCCC_CCCD);
		rk    = 7'(rem_q) * 7'(k_q);
		tail  = (15'(rk) * 15'd205) >> 11;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				qm_q     <= cmd.metric;
				n_q      <= n_new;
				pos_q    <= n_new - CNT_W'(1);
				oldest_q <= wp_q[cmd.metric] - n_new[IDX_W-1:0];
				found_q  <= 1'b0;
				last_q   <= '0;
				med_q    <= '0;
				p90_q    <= '0;
				if (cmd.op == OP_QUERY && &cmd.value) n_q <= '0;
			end
			S_SETUP: begin
				frac_q    <= pos_q[0];
				k_q       <= r10c[3:0];
				rank_q[0] <= pos_q >> 1;
				rank_q[1] <= (pos_q[0] && ((pos_q >> 1) + CNT_W'(1)) < n_q)
				             ? (pos_q >> 1) + CNT_W'(1) : (pos_q >> 1);
				rank_q[2] <= CNT_W'(q10c);
				rank_q[3] <= (r10c != 14'd0 && CNT_W'(q10c) + CNT_W'(1) < n_q)
				             ? CNT_W'(q10c) + CNT_W'(1) : CNT_W'(q10c);
				i_q       <= '0;
				found_q   <= 1'b1;
			end
			S_LDI: begin
				vi_q  <= rdata_q;
				if (i_q == n_q - CNT_W'(1)) last_q <= rdata_q;
				iss_q <= '0;
				cmp_q <= '0;
				lt_q  <= '0;
				eq_q  <= '0;
			end
			S_INNER: begin
				if (iss_q < n_q) iss_q <= iss_q + CNT_W'(1);
				if (vld_s1) begin
					cmp_q <= cmp_q + CNT_W'(1);
					if (rdata_q < vi_q) lt_q <= lt_q + CNT_W'(1);
					if (rdata_q == vi_q) eq_q <= eq_q + CNT_W'(1);
				end
			end
			S_CHECK: begin
				for (int r = 0; r < 4; r++) begin
					if (lt_q <= rank_q[r] && rank_q[r] < lt_q + eq_q) val_q[r] <= vi_q;
				end
				i_q <= i_q + CNT_W'(1);
			end
			S_MUL: begin
				med_q  <= frac_q ? val_q[0] + ((val_q[1] - val_q[0]) >> 1) : val_q[0];
				diff_q <= val_q[3] - val_q[2];
				dcnt_q <= '0;
			end
			S_DIV: begin
				dcnt_q <= dcnt_q + 2'd1;
				if (dcnt_q == 2'd0) quo_q <= recip[62:35];
				if (dcnt_q == 2'd1) begin
					rem_q <= 4'(diff_q - VAL_W'(quo_q) * VAL_W'(4'd10));
					qk_q  <= VAL_W'(quo_q) * VAL_W'(k_q);
				end
				if (dcnt_q == 2'd2) p90_q <= val_q[2] + qk_q + VAL_W'(tail);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
			for (int m = 0; m < NUM_METRICS; m++) begin
				count_q[m] <= '0;
				wp_q[m]    <= '0;
			end
		end else begin
			if (out_valid && !out_stall && state_q != S_OUT) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_ADD: begin
								wp_q[cmd.metric]    <= wp_q[cmd.metric] + IDX_W'(1);
								count_q[cmd.metric] <= (cnt_inc > win_eff) ? win_eff : cnt_inc;
							end
							OP_CLEAR: begin
								for (int m = 0; m < NUM_METRICS; m++) begin
									count_q[m] <= '0;
									wp_q[m]    <= '0;
								end
							end
							OP_QUERY: begin
								state_q <= (n_new == '0 || &cmd.value) ? S_OUT : S_SETUP;
							end
							default: begin
							end
						endcase
					end
				end
				S_SETUP: state_q <= S_RDI;
				S_RDI:   state_q <= S_LDI;
				S_LDI: begin
					vld_s1  <= 1'b0;
					state_q <= S_INNER;
				end
				S_INNER: begin
					vld_s1 <= iss_q < n_q;
					if (vld_s1 && cmp_q == n_q - CNT_W'(1)) state_q <= S_CHECK;
				end
				S_CHECK: state_q <= (i_q == n_q - CNT_W'(1)) ? S_MUL : S_RDI;
				S_MUL:   state_q <= S_DIV;
				S_DIV: begin
					if (dcnt_q == 2'd2) state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid || !out_stall)) begin
			found        <= found_q;
			sample_count <= found_q ? n_q : '0;
			last_value   <= last_q;
			median_value <= med_q;
			p90_value    <= p90_q;
		end
	end
endmodule

>>> src/sliding_window_percentile_tracker.sv
`timescale 1ns / 1ps
// Sliding-window percentile tracker. Eight metric windows of up to 1000 samples each are
// kept in one 8192-entry sample memory. A request with op add stores a sample (negative
// values become zero) and trims the window to window_size; op clear empties all windows;
// op query returns one result with found, count, newest sample, median and 90th
// percentile (linear interpolation between ranks, rounded down). Op code 3 is dropped.
// Requests enter a two-deep queue, so the input keeps accepting while the back end works
// until the queue is full. Add and clear are handled in the idle state. A query on a
// window of n samples makes the back end find each needed rank by walking the window
// once per sample through the single read port of the sample memory, then divide by
// ten through a reciprocal multiply. A query on an empty window skips the search.
// The window_size register, written through cfg_we/cfg_wdata, saturates into
// 10..1000 and must be written only while no request is in flight.
module sliding_window_percentile_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [9:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [2:0]         metric_index,
	input  logic signed [31:0] sample_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [10:0]        sample_count,
	output logic [30:0]        last_value,
	output logic [30:0]        median_value,
	output logic [30:0]        p90_value
);
	import swpt_pkg::*;

	// Raw window size; saturation happens where it is used.
	logic [9:0] win_q;
	cmd_t       push_cmd;
	cmd_t       head;
	logic       push;
	logic       full;
	logic       pop;
	logic       not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
		end else if (cfg_we) begin
			win_q <= cfg_wdata;
		end
	end

	// The front end classifies each request and drops the unused op code.
	swpt_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.metric_index (metric_index),
		.sample_value (sample_value),
		.q_full       (full),
		.q_push       (push),
		.q_cmd        (push_cmd)
	);

	swpt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// The back end owns the sample memory, the per-metric counters and the result register.
	swpt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.win_raw      (win_q),
		.cmd_valid    (not_empty),
		.cmd          (head),
		.cmd_pop      (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.sample_count (sample_count),
		.last_value   (last_value),
		.median_value (median_value),
		.p90_value    (p90_value)
	);
endmodule
